/* hw/rtl/rtf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_pkg
// shared types, constants and register codes of the argb three-tap row filter
// ----------------------------------------------------------------------------
package rtf_pkg;

  localparam int unsigned PIX_W       = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NUM_BYTES   = 4;
  localparam int unsigned COEFF_W     = 16;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned USER_W      = 2;

  // widest row the counters honour, and fraction bits of the weights
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned COEFF_SHIFT = 8;

  // product of a signed weight and a zero-extended byte, and the 3-term sum
  localparam int unsigned PROD_W      = COEFF_W + BYTE_W + 1;
  localparam int unsigned ACC_W       = PROD_W + 2;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic signed [COEFF_W-1:0] COEFF_LEFT_RST   = -16'sd32;
  localparam logic signed [COEFF_W-1:0] COEFF_CENTER_RST = 16'sd320;
  localparam logic signed [COEFF_W-1:0] COEFF_RIGHT_RST  = -16'sd32;
  localparam logic [DIM_W-1:0]          WIDTH_RST        = 13'd1280;
  localparam logic [DIM_W-1:0]          HEIGHT_RST       = 13'd720;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_LEFT   = 3'd0,
    REG_COEFF_CENTER = 3'd1,
    REG_COEFF_RIGHT  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } rtf_reg_e;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff_left;
    logic signed [COEFF_W-1:0] coeff_center;
    logic signed [COEFF_W-1:0] coeff_right;
    logic [DIM_W-1:0]          image_width;
    logic [DIM_W-1:0]          image_height;
  } rtf_cfg_t;

  // one queued job: a pixel window plus how many results it yields
  typedef struct packed {
    logic [PIX_W-1:0] pix_l;
    logic [PIX_W-1:0] pix_c;
    logic [PIX_W-1:0] pix_r;
    logic             row_last;
    logic             frame_last;
    logic             two;
  } rtf_job_t;

endpackage

/* hw/rtl/argb_three_tap_row_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_three_tap_row_filter
// horizontal three-tap q8 filter on bytes 1..3 of a four-byte pixel stream
// ----------------------------------------------------------------------------
// path: a pixel that completes a result word is written to the job queue, then
//   passes the multiply register and the output register; the second word of a
//   row end follows from the same queue entry through the same registers
// throughput: one pixel per cycle while the queue has room; a row end yields
//   two result words, balanced by the row's first pixel which makes no job
// reset: counters, pixel history, queue and valids cleared; weights -32/320/-32,
//   width 1280, height 720
module argb_three_tap_row_filter #(
  parameter int unsigned QUEUE_DEPTH = rtf_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rtf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rtf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rtf_pkg::PIX_W-1:0]         s_axis_tdata,  // pix_ch0, pix_ch1, pix_ch2, pix_ch3
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rtf_pkg::PIX_W-1:0]         m_axis_tdata,  // out_ch0, out_ch1, out_ch2, out_ch3
  output logic                              m_axis_tlast,  // row_end
  output logic [rtf_pkg::USER_W-1:0]        m_axis_tuser   // frame_end, last_result
);
  import rtf_pkg::*;

  rtf_cfg_t cfg_q;
  rtf_job_t push_job, head_job;
  logic     push, q_ready, q_valid, pop;

  // register file: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff_left   <= COEFF_LEFT_RST;
      cfg_q.coeff_center <= COEFF_CENTER_RST;
      cfg_q.coeff_right  <= COEFF_RIGHT_RST;
      cfg_q.image_width  <= WIDTH_RST;
      cfg_q.image_height <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COEFF_LEFT:   cfg_q.coeff_left   <= cfg_data_i;
        REG_COEFF_CENTER: cfg_q.coeff_center <= cfg_data_i;
        REG_COEFF_RIGHT:  cfg_q.coeff_right  <= cfg_data_i;
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // front: position tracking and window building
  rtf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .job_o         (push_job)
  );

  // decoupling queue, ready depends on fill level only
  rtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  // back: multiply stage then sum, round and clamp into the output register
  rtf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .head_i        (head_job),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* hw/rtl/rtf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_front
// takes pixels, tracks row and column, builds filter jobs for the queue
// ----------------------------------------------------------------------------
module rtf_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rtf_pkg::rtf_cfg_t                cfg_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rtf_pkg::PIX_W-1:0]        s_axis_tdata,
  input  logic                             q_ready_i,
  output logic                             push_o,
  output rtf_pkg::rtf_job_t                job_o
);
  import rtf_pkg::*;

  localparam int unsigned WClamp = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;

  logic [DIM_W-1:0] col_q, col_d, row_q, row_d;
  logic [PIX_W-1:0] prev_q, prev_d, prev2_q, prev2_d;
  logic [DIM_W-1:0] w_eff, w_last, h_last;
  logic             accept, col0, row_last, frame_last;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (cfg_i.image_width > DIM_W'(WClamp)) begin
      w_eff = DIM_W'(WClamp);
    end else begin
      w_eff = cfg_i.image_width;
    end
    w_last = w_eff - DIM_W'(1);
    h_last = (cfg_i.image_height == '0) ? '0 : cfg_i.image_height - DIM_W'(1);
  end

  assign s_axis_tready = q_ready_i;
  assign accept        = s_axis_tvalid && q_ready_i;
  assign col0          = (col_q == '0);
  assign row_last      = (col_q >= w_last);
  assign frame_last    = row_last && (row_q >= h_last);

  // first pixel of a wider row only primes the history
  assign push_o = accept && !(col0 && !row_last);

  always_comb begin
    if (col0) begin
      job_o.pix_l = s_axis_tdata;
      job_o.pix_c = s_axis_tdata;
      job_o.pix_r = s_axis_tdata;
      job_o.two   = 1'b0;
    end else begin
      job_o.pix_l = prev2_q;
      job_o.pix_c = prev_q;
      job_o.pix_r = s_axis_tdata;
      job_o.two   = row_last;
    end
    job_o.row_last   = row_last;
    job_o.frame_last = frame_last;
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    prev_d  = prev_q;
    prev2_d = prev2_q;
    if (accept) begin
      prev_d  = s_axis_tdata;
      prev2_d = col0 ? s_axis_tdata : prev_q;
      if (row_last) begin
        col_d = '0;
        row_d = frame_last ? '0 : row_q + DIM_W'(1);
      end else begin
        col_d = col_q + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      prev_q  <= '0;
      prev2_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
    end
  end

endmodule

/* hw/rtl/rtf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_queue
// small job queue between front and back end
// ----------------------------------------------------------------------------
module rtf_queue #(
  parameter int unsigned DEPTH = rtf_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rtf_pkg::rtf_job_t push_job_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rtf_pkg::rtf_job_t head_o
);
  import rtf_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rtf_job_t          mem_q [DEPTH];
  logic [IdxW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign ready_o = (count_q != CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("job queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue read while empty");

endmodule

/* hw/rtl/rtf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_back
// expands jobs into results, multiplies, sums, rounds, clamps, drives output
// ----------------------------------------------------------------------------
module rtf_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rtf_pkg::rtf_cfg_t                cfg_i,
  input  logic                             q_valid_i,
  input  rtf_pkg::rtf_job_t                head_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rtf_pkg::PIX_W-1:0]        m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic [rtf_pkg::USER_W-1:0]       m_axis_tuser
);
  import rtf_pkg::*;

  localparam logic signed [ACC_W-1:0] Round = ACC_W'(1) <<< (COEFF_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] ByteMax = ACC_W'(255);

  logic             phase_q, phase_d;
  logic             issue, s1_free, out_load;
  logic [PIX_W-1:0] sel_l, sel_c, sel_r;
  logic             sel_re, sel_fe, sel_last;

  logic                    s1_vld_q;
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic [BYTE_W-1:0]       s1_ch0_q;
  logic                    s1_re_q, s1_fe_q, s1_last_q;

  logic                    out_vld_q;
  logic [PIX_W-1:0]        out_data_d, out_data_q;
  logic                    out_last_q;
  logic [USER_W-1:0]       out_user_q;

  // second result of a row-end job reuses the head entry with a shifted window
  always_comb begin
    if (phase_q) begin
      sel_l    = head_i.pix_c;
      sel_c    = head_i.pix_r;
      sel_r    = head_i.pix_r;
      sel_re   = 1'b1;
      sel_fe   = head_i.frame_last;
      sel_last = 1'b1;
    end else begin
      sel_l    = head_i.pix_l;
      sel_c    = head_i.pix_c;
      sel_r    = head_i.pix_r;
      sel_re   = head_i.row_last && !head_i.two;
      sel_fe   = head_i.frame_last && !head_i.two;
      sel_last = !head_i.two;
    end
  end

  assign out_load = !out_vld_q || m_axis_tready;
  assign s1_free  = !s1_vld_q || out_load;
  assign issue    = q_valid_i && s1_free;
  assign pop_o    = issue && (!head_i.two || phase_q);
  assign phase_d  = issue ? (head_i.two && !phase_q) : phase_q;

  always_comb begin
    logic signed [BYTE_W:0] b_l, b_c, b_r;
    for (int ch = 0; ch < 3; ch++) begin
      b_l = $signed({1'b0, sel_l[(ch+1)*BYTE_W +: BYTE_W]});
      b_c = $signed({1'b0, sel_c[(ch+1)*BYTE_W +: BYTE_W]});
      b_r = $signed({1'b0, sel_r[(ch+1)*BYTE_W +: BYTE_W]});
      prod_d[ch][0] = cfg_i.coeff_left * b_l;
      prod_d[ch][1] = cfg_i.coeff_center * b_c;
      prod_d[ch][2] = cfg_i.coeff_right * b_r;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc, shifted;
    out_data_d[BYTE_W-1:0] = s1_ch0_q;
    for (int ch = 0; ch < 3; ch++) begin
      acc = Round + ACC_W'(prod_q[ch][0]) + ACC_W'(prod_q[ch][1])
            + ACC_W'(prod_q[ch][2]);
      shifted = acc >>> COEFF_SHIFT;
      if (acc[ACC_W-1]) begin
        out_data_d[(ch+1)*BYTE_W +: BYTE_W] = '0;
      end else if (shifted > ByteMax) begin
        out_data_d[(ch+1)*BYTE_W +: BYTE_W] = '1;
      end else begin
        out_data_d[(ch+1)*BYTE_W +: BYTE_W] = shifted[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (s1_free) begin
        s1_vld_q <= issue;
      end
      if (out_load) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q    <= prod_d;
      s1_ch0_q  <= sel_c[BYTE_W-1:0];
      s1_re_q   <= sel_re;
      s1_fe_q   <= sel_fe;
      s1_last_q <= sel_last;
    end
    if (out_load && s1_vld_q) begin
      out_data_q <= out_data_d;
      out_last_q <= s1_re_q;
      out_user_q <= {s1_last_q, s1_fe_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  a_phase_holds_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (q_valid_i && head_i.two))
    else $error("second result pending without a two-result job at the head");

  a_pop_on_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && head_i.two && !phase_q) |=> (phase_q && !pop_o || issue))
    else $error("row-end job left the head before its second result");

endmodule
